@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks sampled on clk, off while rst is high
`ifndef ASSERT_OFF
`define CHK_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define CHK_CLK(lbl, prop, msg)
`endif

// checks sampled on clk, also during reset
`ifndef ASSERT_OFF
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHK_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/mpt_pkg.sv @@
package mpt_pkg;

  localparam int EXP_BITS = 64;
  localparam int MOD_BITS = 32;

  localparam int EXP_CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
  localparam int MOD_CNT_W = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;

  typedef logic [EXP_BITS-1:0]  exp_t;
  typedef logic [MOD_BITS-1:0]  mod_t;
  typedef logic [MOD_BITS:0]    wide_t;
  typedef logic [EXP_CNT_W-1:0] exp_cnt_t;
  typedef logic [MOD_CNT_W-1:0] mod_cnt_t;

  localparam exp_cnt_t EXP_LAST = exp_cnt_t'(EXP_BITS - 1);
  localparam mod_cnt_t MOD_LAST = mod_cnt_t'(MOD_BITS - 1);
  localparam mod_t     MOD_ZERO = mod_t'(0);
  localparam mod_t     MOD_ONE  = mod_t'(1);

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SQ_GO   = 3'd1;
  localparam logic [2:0] ST_SQ_WAIT = 3'd2;
  localparam logic [2:0] ST_DBL     = 3'd3;
  localparam logic [2:0] ST_FIN     = 3'd4;

endpackage

@@ rtl/core/mpt_mulmod.sv @@
`include "assert_macros.svh"

module mpt_mulmod (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mpt_pkg::mod_t      a,
  input  mpt_pkg::mod_t      b,
  input  mpt_pkg::mod_t      m,
  output mpt_pkg::mod_t      prod,
  output mpt_pkg::mul_stat_t stat
);

  localparam int MOD_BITS_MSB = mpt_pkg::MOD_BITS - 1;

  mpt_pkg::mod_t     acc;
  mpt_pkg::mod_t     mult;
  mpt_pkg::mod_cnt_t cnt;
  logic              busy;
  logic              done;

  mpt_pkg::wide_t m_w;
  mpt_pkg::wide_t dbl;
  mpt_pkg::wide_t dbl_red;
  mpt_pkg::wide_t sum;
  mpt_pkg::wide_t sum_red;

  // one multiplier bit per cycle, msb first
  always_comb begin
    m_w     = {1'b0, m};
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= m_w) ? (dbl - m_w) : dbl;
    sum     = dbl_red + (mult[MOD_BITS_MSB] ? {1'b0, a} : '0);
    sum_red = (sum >= m_w) ? (sum - m_w) : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      mult <= b;
      cnt  <= mpt_pkg::MOD_LAST;
    end else if (busy) begin
      acc  <= sum_red[mpt_pkg::MOD_BITS-1:0];
      mult <= {mult[mpt_pkg::MOD_BITS-2:0], 1'b0};
      cnt  <= cnt - 1'b1;
    end
  end

  assign prod      = acc;
  assign stat.busy = busy;
  assign stat.done = done;

  `CHK_CLK(a_done_idle, done |-> !busy, "done while still busy")
  `CHK_CLK(a_start_busy, start |=> busy, "start did not raise busy")
  `CHK_CLK(a_busy_holds, (busy && !start && (cnt != '0)) |=> busy, "busy dropped early")
  `CHK_ALWAYS(a_rst_idle, rst |=> (!busy && !done), "reset left multiplier active")

endmodule

@@ rtl/core/modular_power_of_two.sv @@
// channel | dir | signals                              | word
// in      | in  | in_valid, in_stall, exponent, modulus | exponent 64b, modulus 32b
// out     | out | out_valid, out_stall, residue        | residue 32b
//
// per exponent bit an item runs a squaring on the bit-serial modular
// multiplier, plus a doubling step for each set bit
// modulus zero skips the exponent bits and ends with residue zero
// rst is synchronous, active high, and clears both channels
// a new word is taken while the last residue waits on out_stall

`include "assert_macros.svh"

module modular_power_of_two (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mpt_pkg::exp_t         exponent,
  input  mpt_pkg::mod_t         modulus,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mpt_pkg::mod_t         residue
);

  logic [2:0]         state;
  mpt_pkg::exp_t      exp_sr;
  mpt_pkg::mod_t      modv;
  mpt_pkg::mod_t      r;
  mpt_pkg::exp_cnt_t  bit_cnt;

  logic               in_acc;
  logic               slot_free;
  logic               mul_start;
  mpt_pkg::mod_t      mul_prod;
  mpt_pkg::mul_stat_t mul_stat;
  mpt_pkg::wide_t     dbl;
  mpt_pkg::wide_t     dbl_red;

  assign in_stall  = (state != mpt_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign mul_start = (state == mpt_pkg::ST_SQ_GO);

  always_comb begin
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= {1'b0, modv}) ? (dbl - {1'b0, modv}) : dbl;
  end

  mpt_mulmod u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (r),
    .b     (r),
    .m     (modv),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mpt_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == mpt_pkg::ST_FIN) && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        mpt_pkg::ST_IDLE: begin
          if (in_acc) begin
            state <= (modulus == mpt_pkg::MOD_ZERO) ? mpt_pkg::ST_FIN : mpt_pkg::ST_SQ_GO;
          end
        end
        mpt_pkg::ST_SQ_GO: begin
          state <= mpt_pkg::ST_SQ_WAIT;
        end
        mpt_pkg::ST_SQ_WAIT: begin
          if (mul_stat.done) begin
            if (exp_sr[mpt_pkg::EXP_BITS-1]) begin
              state <= mpt_pkg::ST_DBL;
            end else if (bit_cnt == '0) begin
              state <= mpt_pkg::ST_FIN;
            end else begin
              state <= mpt_pkg::ST_SQ_GO;
            end
          end
        end
        mpt_pkg::ST_DBL: begin
          state <= (bit_cnt == '0) ? mpt_pkg::ST_FIN : mpt_pkg::ST_SQ_GO;
        end
        mpt_pkg::ST_FIN: begin
          if (slot_free) begin
            state <= mpt_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= mpt_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      exp_sr  <= exponent;
      modv    <= modulus;
      bit_cnt <= mpt_pkg::EXP_LAST;
      r       <= ((modulus == mpt_pkg::MOD_ZERO) || (modulus == mpt_pkg::MOD_ONE)) ?
                 mpt_pkg::MOD_ZERO : mpt_pkg::MOD_ONE;
    end else if ((state == mpt_pkg::ST_SQ_WAIT) && mul_stat.done) begin
      r <= mul_prod;
      if (!exp_sr[mpt_pkg::EXP_BITS-1]) begin
        exp_sr  <= exp_sr << 1;
        bit_cnt <= bit_cnt - 1'b1;
      end
    end else if (state == mpt_pkg::ST_DBL) begin
      r       <= dbl_red[mpt_pkg::MOD_BITS-1:0];
      exp_sr  <= exp_sr << 1;
      bit_cnt <= bit_cnt - 1'b1;
    end
    if ((state == mpt_pkg::ST_FIN) && slot_free) begin
      residue <= r;
    end
  end

  `CHK_CLK(a_done_in_wait,
           mul_stat.done |-> (state == mpt_pkg::ST_SQ_WAIT),
           "stray multiply done")
  `CHK_CLK(a_r_reduced,
           ((state == mpt_pkg::ST_DBL) || (state == mpt_pkg::ST_SQ_GO)) |-> (r < modv),
           "running value not reduced")
  `CHK_CLK(a_fin_reduced,
           ((state == mpt_pkg::ST_FIN) && (modv != mpt_pkg::MOD_ZERO)) |-> (r < modv),
           "final value not reduced")
  `CHK_CLK(a_mul_idle_in_idle,
           (state == mpt_pkg::ST_IDLE) |-> !mul_stat.busy,
           "multiplier busy while idle")

endmodule

@@ tb/modular_power_of_two_test.sv @@
`timescale 1ns / 1ps

module modular_power_of_two_test;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int DRAIN_CYCLES   = 2500;
  localparam int HOLD_CYCLES    = 8000;

  typedef struct {
    mpt_pkg::exp_t exponent;
    mpt_pkg::mod_t modulus;
    mpt_pkg::mod_t residue;
  } power_word_t;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  mpt_pkg::exp_t exponent;
  mpt_pkg::mod_t modulus;
  logic          out_valid;
  logic          out_stall;
  mpt_pkg::mod_t residue;

  power_word_t residue_q[$];
  int          error_count = 0;
  bit          quiet_tx    = 1'b0;
  bit          quiet_rx    = 1'b0;
  bit          hold_req    = 1'b0;

  modular_power_of_two u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .exponent  (exponent),
    .modulus   (modulus),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .residue   (residue)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // square and multiply over the exponent bits, msb first
  function automatic mpt_pkg::mod_t pow2_residue(input mpt_pkg::exp_t e,
                                                 input mpt_pkg::mod_t m);
    logic [63:0] acc;
    if (m == mpt_pkg::MOD_ZERO) return mpt_pkg::MOD_ZERO;
    acc = 64'd1 % 64'(m);
    for (int i = mpt_pkg::EXP_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % 64'(m);
      if (e[i]) acc = (acc * 64'd2) % 64'(m);
    end
    return mpt_pkg::mod_t'(acc);
  endfunction

  function automatic mpt_pkg::exp_t rand_exponent();
    case ($urandom_range(0, 7))
      0: return mpt_pkg::exp_t'($urandom_range(0, 70));
      1: return $urandom_range(0, 1) ? '1 :
                mpt_pkg::exp_t'(1) << $urandom_range(0, mpt_pkg::EXP_BITS - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic mpt_pkg::mod_t rand_modulus();
    int unsigned pick;
    pick = $urandom_range(0, 31);
    if (pick == 0) return mpt_pkg::MOD_ZERO;
    if (pick <= 3) return mpt_pkg::mod_t'($urandom_range(1, 16));
    if (pick <= 5) return mpt_pkg::MOD_ONE << $urandom_range(0, mpt_pkg::MOD_BITS - 1);
    if (pick == 6) return '1 - mpt_pkg::mod_t'($urandom_range(0, 15));
    return mpt_pkg::mod_t'($urandom);
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic send_word(input mpt_pkg::exp_t e, input mpt_pkg::mod_t m);
    int unsigned gap;
    power_word_t w;
    gap = quiet_tx ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    exponent <= e;
    modulus  <= m;
    do @(posedge clk); while (in_stall !== 1'b0);
    w.exponent = e;
    w.modulus  = m;
    w.residue  = pow2_residue(e, m);
    residue_q.push_back(w);
  endtask

  task automatic check_residue(input mpt_pkg::mod_t got);
    power_word_t w;
    if (residue_q.size() == 0) begin
      report_mismatch($sformatf("residue %0h with no word pending", got));
    end else begin
      w = residue_q.pop_front();
      if (got !== w.residue)
        report_mismatch($sformatf("residue %0h, expected %0h (exponent %0h modulus %0h)",
                                  got, w.residue, w.exponent, w.modulus));
    end
  endtask

  task automatic test_special_cases();
    send_word('0, mpt_pkg::MOD_ONE);
    send_word('0, mpt_pkg::mod_t'(2));
    send_word('0, mpt_pkg::mod_t'(3));
    send_word('0, '1);
    send_word('1, mpt_pkg::MOD_ONE);
    send_word({$urandom, $urandom}, mpt_pkg::MOD_ONE);
    send_word('0, mpt_pkg::MOD_ZERO);
    send_word('1, mpt_pkg::MOD_ZERO);
    send_word({$urandom, $urandom}, mpt_pkg::MOD_ZERO);
  endtask

  task automatic test_extremes();
    send_word('1, '1);
    send_word(mpt_pkg::exp_t'(1), '1);
    send_word(mpt_pkg::exp_t'(1), mpt_pkg::mod_t'(2));
    send_word(mpt_pkg::exp_t'(1), mpt_pkg::mod_t'(3));
    send_word(mpt_pkg::exp_t'(31), 32'h8000_0000);
    send_word(mpt_pkg::exp_t'(31), 32'h8000_0001);
    send_word(64'h8000_0000_0000_0000, 32'h8000_0000);
    send_word(64'h8000_0000_0000_0000, '1);
    send_word(64'h5555_5555_5555_5555, 32'hAAAA_AAAB);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
  endtask

  task automatic test_random(input int n);
    repeat (n) send_word(rand_exponent(), rand_modulus());
  endtask

  task automatic test_streaming(input int n);
    quiet_tx = 1'b1;
    quiet_rx = 1'b1;
    repeat (n) send_word(rand_exponent(), rand_modulus());
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
  endtask

  // receiver holds off while words keep coming, so the input has to stall
  task automatic test_backpressure(input int n);
    quiet_tx = 1'b1;
    hold_req = 1'b1;
    repeat (n) send_word({$urandom, $urandom}, mpt_pkg::mod_t'($urandom) | 32'h0000_1000);
    quiet_tx = 1'b0;
  endtask

  initial begin : drain
    int unsigned wait_left;
    int unsigned hold_left;
    bit          hold_done;
    wait_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        check_residue(residue);
        wait_left = quiet_rx ? 0 : $urandom_range(0, 15);
      end else if (out_valid && wait_left != 0) begin
        wait_left--;
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (wait_left != 0);
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("modular_power_of_two test failed");
    $finish;
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    exponent = '0;
    modulus  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_special_cases();
    test_extremes();
    test_random(225);
    test_streaming(20);
    test_backpressure(6);
    in_valid <= 1'b0;
    while (residue_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("modular_power_of_two test passed");
    end else begin
      $display("modular_power_of_two test failed");
    end
    $finish;
  end

endmodule
